// ===== rtl/klc_pkg.sv =====
// shared types, codes and keyword constants of the keyword language classifier
package klc_pkg;

  // selector codes on the input side
  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_END    = 2'd1;
  localparam logic [1:0] FUNC_ABSENT = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // result codes
  localparam logic [2:0] LANG_EN  = 3'd0;
  localparam logic [2:0] LANG_ES  = 3'd1;
  localparam logic [2:0] LANG_FR  = 3'd2;
  localparam logic [2:0] LANG_DE  = 3'd3;
  localparam logic [2:0] LANG_IT  = 3'd4;
  localparam logic [2:0] LANG_PT  = 3'd5;
  localparam logic [2:0] LANG_MUL = 3'd6;
  localparam logic [2:0] LANG_UND = 3'd7;

  // positions of the sticky flags
  localparam int unsigned LANG_COUNT = 5;
  localparam logic [2:0] SEEN_ES = 3'd0;
  localparam logic [2:0] SEEN_FR = 3'd1;
  localparam logic [2:0] SEEN_DE = 3'd2;
  localparam logic [2:0] SEEN_IT = 3'd3;
  localparam logic [2:0] SEEN_PT = 3'd4;

  localparam int unsigned WINDOW_BYTES = 6;
  localparam int unsigned WINDOW_BITS  = 8 * WINDOW_BYTES;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef logic [WINDOW_BITS-1:0] window_t;
  typedef logic [LANG_COUNT-1:0]  seen_t;

  // keywords right-aligned, first character in the highest used byte, newest window byte lowest
  localparam int unsigned KW_COUNT = 39;

  localparam window_t KW_WORD [KW_COUNT] = '{
    window_t'(" el "),   window_t'(" la "),   window_t'(" de "),   window_t'(" que "),
    window_t'(" es "),   window_t'(" con "),  window_t'(" y "),    window_t'(" en "),
    window_t'(" un "),   window_t'(" una "),
    window_t'(" le "),   window_t'(" et "),   window_t'(" ce "),   window_t'(" qui "),
    window_t'(" avec "), window_t'(" est "),  window_t'(" dans "), window_t'(" pour "),
    window_t'(" und "),  window_t'(" der "),  window_t'(" die "),  window_t'(" das "),
    window_t'(" mit "),  window_t'(" ist "),  window_t'(" ein "),  window_t'(" eine "),
    window_t'(" auf "),  window_t'(" von "),
    window_t'(" il "),   window_t'(" che "),  window_t'(" per "),  window_t'(" sono "),
    window_t'(" in "),   window_t'(" non "),
    window_t'(" para "), window_t'(" com "),  window_t'(" em "),   window_t'(" um "),
    window_t'(" uma ")
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4, 3'd5,
    3'd4, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd6,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd5, 3'd5,
    3'd4, 3'd5, 3'd5, 3'd6, 3'd4, 3'd5,
    3'd6, 3'd5, 3'd4, 3'd4, 3'd5
  };

  localparam logic [2:0] KW_LANG [KW_COUNT] = '{
    SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES,
    SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR,
    SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE,
    SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT,
    SEEN_PT, SEEN_PT, SEEN_PT, SEEN_PT, SEEN_PT
  };

  // mask over the newest len bytes of the window
  function automatic window_t kw_mask(input logic [2:0] len);
    window_t ones;
    ones = '1;
    return ones >> (8 * (WINDOW_BYTES - int'(len)));
  endfunction

  // one registered input item on its way into the text state
  typedef struct packed {
    logic       go;
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
  } klc_step_t;

  // what the text state hands back for the result register
  typedef struct packed {
    logic       emit;
    logic [2:0] code;
  } klc_result_t;

endpackage

// ===== rtl/klc_match.sv =====
// keyword matcher: flags every language whose keyword ends the window
module klc_match (
  input  klc_pkg::window_t window,
  output klc_pkg::seen_t   hits
);
  import klc_pkg::*;

  always_comb begin
    hits = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((window & kw_mask(KW_LEN[k])) == KW_WORD[k]) begin
        hits[KW_LANG[k]] = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/klc_text_state.sv =====
// per-text state: byte window, sticky flags, counters and the final decision
module klc_text_state #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  klc_pkg::klc_step_t   step,
  output klc_pkg::klc_result_t result
);
  import klc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [3:0] REM_LAST = 4'd9;

  window_t               window;
  seen_t                 seen;
  logic [3:0]            tenth_rem;
  logic [COUNT_BITS-1:0] length_tenths;
  logic [COUNT_BITS-1:0] non_ascii;

  window_t               window_next;
  seen_t                 seen_next;
  seen_t                 hits;
  logic [3:0]            tenth_rem_next;
  logic [COUNT_BITS-1:0] length_tenths_next;
  logic [COUNT_BITS-1:0] non_ascii_next;
  logic [7:0]            folded;
  logic                  take;
  logic                  clear;

  function automatic logic [2:0] pick(input seen_t s, input logic [COUNT_BITS-1:0] na,
                                      input logic [COUNT_BITS-1:0] lt);
    logic [2:0] code;
    if (s[SEEN_ES]) begin
      code = LANG_ES;
    end else if (s[SEEN_FR]) begin
      code = LANG_FR;
    end else if (s[SEEN_DE]) begin
      code = LANG_DE;
    end else if (s[SEEN_IT]) begin
      code = LANG_IT;
    end else if (s[SEEN_PT]) begin
      code = LANG_PT;
    end else if (na > lt) begin
      code = LANG_MUL;
    end else begin
      code = LANG_EN;
    end
    return code;
  endfunction

  // fold ascii capitals
  assign folded = (step.data >= CHAR_UPPER_A && step.data <= CHAR_UPPER_Z) ?
                  step.data + CASE_OFFSET : step.data;

  assign window_next = {window[WINDOW_BITS-9:0], folded};

  klc_match u_match (
    .window (window_next),
    .hits   (hits)
  );

  assign seen_next = seen | hits;

  always_comb begin
    non_ascii_next = non_ascii;
    if (folded[7] && non_ascii != COUNT_MAX) begin
      non_ascii_next = non_ascii + 1'b1;
    end
    tenth_rem_next     = tenth_rem;
    length_tenths_next = length_tenths;
    if (length_tenths != COUNT_MAX) begin
      if (tenth_rem >= REM_LAST) begin
        tenth_rem_next     = '0;
        length_tenths_next = length_tenths + 1'b1;
      end else begin
        tenth_rem_next = tenth_rem + 1'b1;
      end
    end
  end

  always_comb begin
    take        = 1'b0;
    clear       = 1'b0;
    result.emit = 1'b0;
    result.code = LANG_EN;
    unique case (step.func)
      FUNC_BYTE: begin
        take        = step.go && !step.last;
        clear       = step.go && step.last;
        result.emit = step.go && step.last;
        result.code = pick(seen_next, non_ascii_next, length_tenths_next);
      end
      FUNC_END: begin
        clear       = step.go;
        result.emit = step.go;
        result.code = pick(seen, non_ascii, length_tenths);
      end
      FUNC_ABSENT: begin
        clear       = step.go;
        result.emit = step.go;
        result.code = LANG_UND;
      end
      FUNC_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      window        <= '0;
      seen          <= '0;
      tenth_rem     <= '0;
      length_tenths <= '0;
      non_ascii     <= '0;
    end else if (take) begin
      window        <= window_next;
      seen          <= seen_next;
      tenth_rem     <= tenth_rem_next;
      length_tenths <= length_tenths_next;
      non_ascii     <= non_ascii_next;
    end
  end

endmodule

// ===== rtl/keyword_language_classifier.sv =====
// top level of the keyword language classifier: input register, text state, result register
//
// The block reads a text one item per byte and answers once per text with a
// language code. Each byte is registered on entry; when it moves on, capitals are
// folded, the byte is shifted into a six-byte window, the window is compared
// against all keywords of es, fr, de, it and pt at once, and the byte and
// non-ascii counters step; the answer goes into an output register. An item can
// be taken every cycle unless the result register is blocked, so the rate is then
// one byte per clock; a result passes the input and the result register before it
// reaches the master side. The cycle time is set by the keyword compare feeding
// the priority pick and the counter compare into the result register. The slave
// side stalls only while the result register is full and not being taken. After
// a result (or an absent text) all per-text state is back at its reset value.
module keyword_language_classifier #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic [1:0] s_tuser,   // [1:0] func
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] language_code, [7:3] zero
);
  import klc_pkg::*;

  // input register
  logic        in_valid;
  logic [1:0]  in_func;
  logic [7:0]  in_data;
  logic        in_last;

  // result register
  logic        out_valid;
  logic [2:0]  out_code;

  logic        advance;
  klc_step_t   step;
  klc_result_t result;

  // the registered item moves on whenever the result register has room
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign step.go   = advance;
  assign step.func = in_func;
  assign step.data = in_data;
  assign step.last = in_last;

  klc_text_state #(
    .COUNT_BITS (COUNT_BITS)
  ) u_text_state (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (result)
  );

  // result register, refilled in the same cycle it is emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_code <= result.code;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_code};

  // the slave side only stalls behind a full, blocked result register
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // an absent text answers und in the next cycle
  a_absent_gives_und: assert property (@(posedge clk) disable iff (rst)
    (advance && in_func == FUNC_ABSENT) |=> (m_tvalid && m_tdata[2:0] == LANG_UND))
    else $error("absent text did not give und");

  // a byte that does not close the text gives no result
  a_mid_byte_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && in_func == FUNC_BYTE && !in_last) |=> !m_tvalid)
    else $error("result emitted for a byte inside the text");

  // the unused selector is dropped without a result
  a_unused_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && in_func == FUNC_NONE) |=> !m_tvalid)
    else $error("result emitted for the unused selector");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the keyword language classifier
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import klc_pkg::*;

  // narrow counters so that saturation is reachable in a short run
  localparam int unsigned CNT_BITS     = 8;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned KW_TOTAL     = 39;
  localparam int unsigned MAX_REPORTS  = 10;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] text_byte
  logic [1:0] s_tuser;   // [1:0] func
  logic       s_tlast;   // last_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [2:0] language_code, [7:3] zero

  keyword_language_classifier #(
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // keyword list with its sticky flag, spaces on both sides of every word
  string kw_text [KW_TOTAL] = '{
    " el ", " la ", " de ", " que ", " es ", " con ", " y ", " en ", " un ", " una ",
    " le ", " et ", " ce ", " qui ", " avec ", " est ", " dans ", " pour ",
    " und ", " der ", " die ", " das ", " mit ", " ist ", " ein ", " eine ", " auf ", " von ",
    " il ", " che ", " per ", " sono ", " in ", " non ",
    " para ", " com ", " em ", " um ", " uma "
  };
  logic [2:0] kw_flag [KW_TOTAL] = '{
    SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES, SEEN_ES,
    SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR, SEEN_FR,
    SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE, SEEN_DE,
    SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT, SEEN_IT,
    SEEN_PT, SEEN_PT, SEEN_PT, SEEN_PT, SEEN_PT
  };
  // answer for each flag position, in priority order
  logic [2:0] flag_code [LANG_COUNT] = '{LANG_ES, LANG_FR, LANG_DE, LANG_IT, LANG_PT};

  // predicted per-text state
  window_t             text_window;
  seen_t               text_seen;
  logic [3:0]          text_rem;
  logic [CNT_BITS-1:0] text_tenths;
  logic [CNT_BITS-1:0] text_high;

  // language codes still to come out of the block, oldest first
  logic [2:0] lang_expected [$];

  int unsigned mismatches;
  int unsigned data_items;    // accepted items other than the unused selector
  int unsigned cycle_count;
  int unsigned hold_cycles;   // long receiver hold-off, counted down by the sink
  bit          gaps_on;       // sender idle bursts
  bit          stall_en;      // receiver stall bursts
  logic [2:0]  got_want;

  // ------------------------------------------------------------------
  // clock and cycle limit
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------
  function automatic bit window_ends_with(input string w);
    bit hit;
    int n;
    n = w.len();
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      // first character sits in the oldest of the newest n bytes
      if (text_window[8*(n-1-i) +: 8] != w[i]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [2:0] pick_language();
    for (int i = 0; i < LANG_COUNT; i++) begin
      if (text_seen[i]) return flag_code[i];
    end
    // only an en answer can turn into mul
    if (text_high > text_tenths) return LANG_MUL;
    return LANG_EN;
  endfunction

  task automatic clear_text();
    text_window = '0;
    text_seen   = '0;
    text_rem    = '0;
    text_tenths = '0;
    text_high   = '0;
  endtask

  task automatic classify_item(input logic [1:0] f, input logic [7:0] b, input logic l);
    logic [7:0] c;
    c = b;
    case (f)
      FUNC_BYTE: begin
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
        text_window = {text_window[WINDOW_BITS-9:0], c};
        for (int k = 0; k < KW_TOTAL; k++) begin
          if (window_ends_with(kw_text[k])) text_seen[kw_flag[k]] = 1'b1;
        end
        if (c[7] && text_high != '1) text_high = text_high + 1'b1;
        // remainder freezes together with the saturated tenths count
        if (text_tenths != '1) begin
          if (text_rem >= 4'd9) begin
            text_rem    = '0;
            text_tenths = text_tenths + 1'b1;
          end else begin
            text_rem = text_rem + 1'b1;
          end
        end
        if (l) begin
          lang_expected.push_back(pick_language());
          clear_text();
        end
      end
      FUNC_END: begin
        lang_expected.push_back(pick_language());
        clear_text();
      end
      FUNC_ABSENT: begin
        lang_expected.push_back(LANG_UND);
        clear_text();
      end
      default: begin
        // unused selector leaves everything as it is
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // sender: one item per call, fields change at the falling edge
  // ------------------------------------------------------------------
  task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic l);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = 8'($urandom);
        s_tuser  = 2'($urandom);
        s_tlast  = 1'($urandom);
      end
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = f;
    s_tlast  = l;
    do @(posedge clk); while (!s_tready);
    classify_item(f, b, l);
    if (f != FUNC_NONE) data_items++;
  endtask

  task automatic send_string(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i], mark_last && i == s.len() - 1);
  endtask

  // one text of bytes at 128 and above, closed by last_byte
  task automatic send_high_text(input int unsigned len);
    for (int unsigned n = 1; n <= len; n++) begin
      send_item(FUNC_BYTE, 8'($urandom_range(128, 255)), n == len);
    end
  endtask

  // a text built from keywords, filler words, utf-8 style bytes and noise
  task automatic send_random_text();
    logic [7:0]  txt [$];
    string       w;
    int unsigned flavour;
    int unsigned n_words;
    int unsigned piece;
    int unsigned ending;
    int unsigned cut;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    flavour = $urandom_range(0, 9);   // 0-4 keywords, 5-7 plain, 8-9 mostly non-ascii
    n_words = $urandom_range(1, 8);
    if ($urandom_range(0, 1)) txt.push_back(8'h20);
    for (i = 0; i < n_words; i++) begin
      piece = $urandom_range(0, 9);
      if (flavour < 5 && piece < 4) begin
        w = kw_text[$urandom_range(0, KW_TOTAL - 1)];
        for (j = 1; j + 1 < w.len(); j++) txt.push_back(w[j]);
      end else if (flavour >= 8 || piece == 9) begin
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(128, 255)));
      end else if (piece == 8) begin
        txt.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      if ($urandom_range(0, 4) != 0) txt.push_back(8'h20);
    end
    // capitals here and there, folded back by the block
    foreach (txt[m]) begin
      if (txt[m] >= 8'h61 && txt[m] <= 8'h7A && $urandom_range(0, 3) == 0) begin
        txt[m] = txt[m] - CASE_OFFSET;
      end
    end
    // mostly closed by last_byte, sometimes by an end item, sometimes cut off as absent
    ending = $urandom_range(0, 9);
    cut = txt.size();
    if (ending == 9) cut = $urandom_range(0, txt.size() - 1);
    for (k = 0; k < cut; k++) begin
      if ($urandom_range(0, 24) == 0) send_item(FUNC_NONE, 8'($urandom), 1'($urandom));
      send_item(FUNC_BYTE, txt[k], ending < 7 && k == cut - 1);
    end
    if (ending == 7 || ending == 8) send_item(FUNC_END, 8'($urandom), 1'($urandom));
    else if (ending == 9) send_item(FUNC_ABSENT, 8'($urandom), 1'($urandom));
  endtask

  // ------------------------------------------------------------------
  // sink: random stall bursts plus an optional long hold-off
  // ------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready    = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
        m_tready   = 1'b0;
        stall_left = stall_left - 1;
      end else if (stall_en && $urandom_range(0, 6) == 0) begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // result checker: each accepted item against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (lang_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb_top: result %0d arrived with nothing expected", m_tdata);
        end
      end else begin
        got_want = lang_expected.pop_front();
        if (m_tdata !== {5'd0, got_want}) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("tb_top: language code mismatch, expected %0d got %0d", got_want, m_tdata);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    send_item(FUNC_ABSENT, 8'hFF, 1'b1);   // absent text, last ignored
    send_item(FUNC_END, 8'h00, 1'b0);      // empty text gives en
    send_string(" EL ", 1'b1);             // capitals fold, es
    send_string(" avec ", 1'b1);           // keyword fills the whole window, fr
    send_item(FUNC_NONE, 8'hA5, 1'b1);     // unused selector is ignored
    // zero byte, both neighbours of the capital range and a top byte: mul
    send_item(FUNC_BYTE, 8'h00, 1'b0);
    send_item(FUNC_BYTE, 8'h40, 1'b0);
    send_item(FUNC_BYTE, 8'h5B, 1'b0);
    send_item(FUNC_BYTE, 8'hFF, 1'b1);
    // de beats it, closed by an end item carrying a stray last
    send_string(" und il ", 1'b0);
    send_item(FUNC_END, 8'h5A, 1'b1);
  endtask

  task automatic test_counter_saturation();
    send_high_text(260);    // non-ascii count stops at its maximum, still above the tenths
  endtask

  task automatic test_backpressure();
    hold_cycles = 250;
    repeat (40) send_item(FUNC_ABSENT, 8'($urandom), 1'($urandom));
    send_random_text();
  endtask

  task automatic test_random_texts(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = data_items;
    while (data_items - start < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_item(FUNC_END, 8'($urandom), 1'($urandom));
      else if (pick == 1) send_item(FUNC_ABSENT, 8'($urandom), 1'($urandom));
      else send_random_text();
    end
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = FUNC_BYTE;
    s_tlast     = 1'b0;
    mismatches  = 0;
    data_items  = 0;
    cycle_count = 0;
    hold_cycles = 0;
    gaps_on     = 1'b1;
    stall_en    = 1'b1;
    clear_text();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_counter_saturation();
    test_backpressure();
    test_random_texts(RANDOM_ITEMS - 150);
    // steady flow at the end, no idling on either side
    gaps_on  = 1'b0;
    stall_en = 1'b0;
    test_random_texts(150);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (lang_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
